/* src/byte_ring_buffer_core_defines.svh */
// ---------------------------------------------------------------------------
// Byte ring buffer assertion macros
// Shared concurrent check helpers for the byte ring buffer modules.
// ---------------------------------------------------------------------------
`ifndef BYTE_RING_BUFFER_CORE_DEFINES_SVH
`define BYTE_RING_BUFFER_CORE_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define BRB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("byte ring buffer check failed");

// Check a consequent in the cycle after its antecedent.
`define BRB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("byte ring buffer check failed");

`endif

/* src/brb_pkg.sv */
// ---------------------------------------------------------------------------
// Byte ring buffer package
// Sizes, action and status codes, word types and pointer arithmetic.
// ---------------------------------------------------------------------------
`default_nettype none

package brb_pkg;

    localparam int SLOTS     = 1024;
    localparam int MAX_BURST = 64;
    localparam int PTR_W     = $clog2(SLOTS);
    localparam int COUNT_W   = 7;
    localparam int SIZE_W    = 10;
    localparam int BYTE_W    = 8;

    localparam logic [PTR_W:0] SLOTS_X = (PTR_W + 1)'(SLOTS);

    typedef logic [PTR_W-1:0] t_ptr;

    typedef enum logic [2:0] {
        A_WRITE      = 3'd0,
        A_READ       = 3'd1,
        A_PEEK       = 3'd2,
        A_MOVE_FRONT = 3'd3,
        A_BACK_FRONT = 3'd4,
        A_MOVE_REAR  = 3'd5,
        A_BACK_REAR  = 3'd6,
        A_CLEAR      = 3'd7
    } t_action;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SIZE = 2'd1,
        ST_MOVE = 2'd2
    } t_status;

    typedef struct packed {
        t_action              action;
        logic [BYTE_W-1:0]    data_byte;
        logic [COUNT_W-1:0]   count;
    } t_in;

    typedef struct packed {
        logic [BYTE_W-1:0]    out_byte;
        logic                 byte_valid;
        logic                 last;
        t_status              status;
        logic [SIZE_W-1:0]    used_size;
        logic [SIZE_W-1:0]    free_size;
    } t_out;

    // controller -> datapath
    typedef struct packed {
        logic sweep;
        logic take;
        logic emit_resp;
        logic emit_byte;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic sweep_done;
        logic burst_start;
        logic out_free;
        logic last_byte;
    } t_stat;

    // a + n modulo SLOTS, both below SLOTS
    function automatic t_ptr ptr_add(input t_ptr a, input t_ptr n);
        logic [PTR_W:0] s;
        s = {1'b0, a} + {1'b0, n};
        if (s >= SLOTS_X) begin
            s = s - SLOTS_X;
        end
        return s[PTR_W-1:0];
    endfunction

    // a - b modulo SLOTS, both below SLOTS
    function automatic t_ptr ptr_sub(input t_ptr a, input t_ptr b);
        logic [PTR_W:0] d;
        d = {1'b0, a} - {1'b0, b};
        if (d[PTR_W]) begin
            d = d + SLOTS_X;
        end
        return d[PTR_W-1:0];
    endfunction

    // count modulo SLOTS as a small lookup over every count value
    function automatic t_ptr count_mod(input logic [COUNT_W-1:0] c);
        t_ptr r;
        t_ptr m;
        r = '0;
        m = '0;
        for (int i = 0; i < 2 ** COUNT_W; i++) begin
            if (COUNT_W'(i) == c) begin
                r = m;
            end
            m = (m == t_ptr'(SLOTS - 1)) ? '0 : m + t_ptr'(1);
        end
        return r;
    endfunction

    // fit a pointer-wide size into the reported field
    function automatic logic [SIZE_W-1:0] to_size(input t_ptr x);
        logic [31:0] t;
        t = 32'(x);
        return t[SIZE_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* src/brb_ctrl.sv */
// ---------------------------------------------------------------------------
// Byte ring buffer controller
// Sequences the clearing pass, item intake, single results and byte bursts.
// ---------------------------------------------------------------------------
`default_nettype none
`include "byte_ring_buffer_core_defines.svh"

module brb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  brb_pkg::t_stat i_stat,
    output brb_pkg::t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_RESP,
        S_BURST
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.sweep = 1'b1;
                if (i_stat.sweep_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = i_stat.burst_start ? S_BURST : S_RESP;
                end
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_resp = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_BURST: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_byte = 1'b1;
                    if (i_stat.last_byte) begin
                        n_state = S_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    `BRB_ASSERT_NEXT(a_burst_ends_idle, i_clk, i_rst_n,
        (r_state == S_BURST) && i_stat.out_free && i_stat.last_byte, r_state == S_IDLE)

endmodule

`default_nettype wire

/* src/brb_dp.sv */
// ---------------------------------------------------------------------------
// Byte ring buffer datapath
// Byte memory, front and rear pointers, burst counter and output register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "byte_ring_buffer_core_defines.svh"

module brb_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  brb_pkg::t_in   i_in,
    input  brb_pkg::t_cmd  i_cmd,
    output brb_pkg::t_stat o_stat,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    output brb_pkg::t_out  o_out
);

    brb_pkg::t_ptr r_front;
    brb_pkg::t_ptr r_rear;
    brb_pkg::t_ptr r_sweep;
    brb_pkg::t_ptr r_rd_addr;
    brb_pkg::t_ptr n_front;
    brb_pkg::t_ptr n_rear;
    brb_pkg::t_ptr used;
    brb_pkg::t_ptr free;
    brb_pkg::t_ptr rd_addr;
    brb_pkg::t_ptr wr_addr;

    logic [brb_pkg::COUNT_W-1:0] r_left;
    logic [brb_pkg::BYTE_W-1:0]  r_mem [brb_pkg::SLOTS];
    logic [brb_pkg::BYTE_W-1:0]  r_rd_data;
    logic [brb_pkg::BYTE_W-1:0]  wr_data;

    brb_pkg::t_status r_status;
    brb_pkg::t_status n_status;
    brb_pkg::t_out    r_out;
    logic             r_out_valid;

    logic        rd_ok;
    logic        is_rd;
    logic        wr_en;
    logic        rd_en;
    logic        last_byte;
    logic        out_free;
    logic [31:0] cnt_wide;

    assign used      = brb_pkg::ptr_sub(r_rear, r_front);
    assign free      = brb_pkg::t_ptr'(brb_pkg::SLOTS - 1) - used;
    assign cnt_wide  = 32'(i_in.count);
    assign rd_ok     = (i_in.count != '0) && (cnt_wide <= 32'(used))
                     && (cnt_wide <= 32'(brb_pkg::MAX_BURST));
    assign is_rd     = (i_in.action == brb_pkg::A_READ) || (i_in.action == brb_pkg::A_PEEK);
    assign last_byte = (r_left == brb_pkg::COUNT_W'(1));
    assign out_free  = !r_out_valid || i_out_ready;

    assign o_stat.sweep_done  = (r_sweep == brb_pkg::t_ptr'(brb_pkg::SLOTS - 1));
    assign o_stat.burst_start = is_rd && rd_ok;
    assign o_stat.out_free    = out_free;
    assign o_stat.last_byte   = last_byte;

    // action decode: next pointers and status
    always_comb begin
        n_front  = r_front;
        n_rear   = r_rear;
        n_status = brb_pkg::ST_OK;
        unique case (i_in.action)
            brb_pkg::A_WRITE: begin
                if (free == '0) begin
                    n_status = brb_pkg::ST_SIZE;
                end else begin
                    n_rear = brb_pkg::ptr_add(r_rear, brb_pkg::t_ptr'(1));
                end
            end
            brb_pkg::A_READ: begin
                if (rd_ok) begin
                    n_front = brb_pkg::ptr_add(r_front, brb_pkg::t_ptr'(i_in.count));
                end else begin
                    n_status = brb_pkg::ST_SIZE;
                end
            end
            brb_pkg::A_PEEK: begin
                if (!rd_ok) begin
                    n_status = brb_pkg::ST_SIZE;
                end
            end
            brb_pkg::A_MOVE_FRONT: begin
                if (cnt_wide > 32'(used)) begin
                    n_status = brb_pkg::ST_MOVE;
                end else begin
                    n_front = brb_pkg::ptr_add(r_front, brb_pkg::t_ptr'(i_in.count));
                end
            end
            brb_pkg::A_BACK_FRONT: begin
                n_front = brb_pkg::ptr_sub(r_front, brb_pkg::count_mod(i_in.count));
            end
            brb_pkg::A_MOVE_REAR: begin
                if (cnt_wide > 32'(free)) begin
                    n_status = brb_pkg::ST_MOVE;
                end else begin
                    n_rear = brb_pkg::ptr_add(r_rear, brb_pkg::t_ptr'(i_in.count));
                end
            end
            brb_pkg::A_BACK_REAR: begin
                n_rear = brb_pkg::ptr_sub(r_rear, brb_pkg::count_mod(i_in.count));
            end
            brb_pkg::A_CLEAR: begin
                n_front = '0;
                n_rear  = '0;
            end
        endcase
    end

    // memory port selection
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_rear;
        wr_data = i_in.data_byte;
        if (i_cmd.sweep) begin
            wr_en   = 1'b1;
            wr_addr = r_sweep;
            wr_data = '0;
        end else if (i_cmd.take && (i_in.action == brb_pkg::A_WRITE) && (free != '0)) begin
            wr_en = 1'b1;
        end
    end

    assign rd_en   = i_cmd.take || (i_cmd.emit_byte && !last_byte);
    assign rd_addr = i_cmd.take ? r_front : r_rd_addr;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= '0;
            r_rear      <= '0;
            r_sweep     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.sweep) begin
                r_sweep <= r_sweep + brb_pkg::t_ptr'(1);
            end
            if (i_cmd.take) begin
                r_front <= n_front;
                r_rear  <= n_rear;
            end
            if (i_cmd.emit_resp || i_cmd.emit_byte) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_status  <= n_status;
            r_left    <= i_in.count;
            r_rd_addr <= brb_pkg::ptr_add(r_front, brb_pkg::t_ptr'(1));
        end else if (i_cmd.emit_byte) begin
            r_left <= r_left - brb_pkg::COUNT_W'(1);
            if (!last_byte) begin
                r_rd_addr <= brb_pkg::ptr_add(r_rd_addr, brb_pkg::t_ptr'(1));
            end
        end
        if (i_cmd.emit_byte) begin
            r_out.out_byte   <= r_rd_data;
            r_out.byte_valid <= 1'b1;
            r_out.last       <= last_byte;
            r_out.status     <= brb_pkg::ST_OK;
            r_out.used_size  <= brb_pkg::to_size(used);
            r_out.free_size  <= brb_pkg::to_size(free);
        end else if (i_cmd.emit_resp) begin
            r_out.out_byte   <= '0;
            r_out.byte_valid <= 1'b0;
            r_out.last       <= 1'b1;
            r_out.status     <= r_status;
            r_out.used_size  <= brb_pkg::to_size(used);
            r_out.free_size  <= brb_pkg::to_size(free);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `BRB_ASSERT_NOW(a_emit_has_bytes, i_clk, i_rst_n,
        i_cmd.emit_byte, r_left != '0)
    `BRB_ASSERT_NOW(a_sweep_quiet, i_clk, i_rst_n,
        i_cmd.sweep, !r_out_valid)
    `BRB_ASSERT_NEXT(a_burst_len, i_clk, i_rst_n,
        i_cmd.take && o_stat.burst_start,
        (r_left != '0) && (32'(r_left) <= 32'(brb_pkg::MAX_BURST)))

endmodule

`default_nettype wire

/* src/byte_ring_buffer_core.sv */
// ---------------------------------------------------------------------------
// Byte ring buffer core
// Circular byte FIFO with per-word actions and burst read-out.
// ---------------------------------------------------------------------------
// The buffer holds up to SLOTS-1 bytes in a single-port-write byte memory;
// one cell always stays empty so full and empty differ. Each input word
// carries an action: write one byte at the rear, read or peek a burst of
// count bytes from the front (read also advances the front), move the front
// or rear forward within the used or free space, step either pointer back
// modulo SLOTS with no bound, or clear both pointers. A read or peek that
// passes its checks gives count output words, one byte each, with last on
// the final one; every other action, and a refused read or peek, gives one
// output word with last set. used_size and free_size always report the
// buffer after the action. After reset the memory is swept to zero, one
// byte per cycle over all SLOTS cells, and no input word is taken until
// the sweep is done. A non-burst action takes the word, then loads the
// output register; a burst takes the word, then loads one byte per cycle
// while the output is free, fed by the registered read port of the byte
// memory. The input is taken only between actions. Output backpressure
// holds the burst in place without loss.
// ---------------------------------------------------------------------------
`default_nettype none

module byte_ring_buffer_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  brb_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output brb_pkg::t_out o_out
);

    // command and status between sequencer and datapath
    brb_pkg::t_cmd  cmd;
    brb_pkg::t_stat stat;

    // sequencer: sweep, take word, drive single result or byte burst
    brb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // datapath: memory, pointers, output register
    brb_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire
